### rtl/nci_pkg.sv
// ----------------------------------------------------------------------------
// nci_pkg
// Shared types, constants and saturation helpers for the four-point
// Neville cubic interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package nci_pkg;

  localparam int DW   = 32;   // data width, signed fixed point
  localparam int FB   = 16;   // fraction bits
  localparam int NPTS = 4;    // sample points
  localparam int NL   = 3;    // tableau lanes in the first column

  localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};

  // one tableau item as it travels down the pipeline
  typedef struct packed {
    logic [NPTS-1:0][DW-1:0] xa;
    logic [DW-1:0]           q;
    logic [NPTS-1:0][DW-1:0] c;
    logic [NPTS-1:0][DW-1:0] d;
    logic [DW-1:0]           y;
    logic signed [2:0]       ns;
    logic                    ovf;
    logic                    err;
  } tab_t;

  // restoring divider state of one lane
  typedef struct packed {
    logic [DW-1:0] r;
    logic [DW-1:0] qlo;
    logic [DW-1:0] dv;
    logic          neg;
    logic          big;
  } lane_t;

  typedef lane_t [NL-1:0] lanes_t;

  // saturated value with its overflow mark
  typedef struct packed {
    logic [DW-1:0] v;
    logic          o;
  } satr_t;

  // exact difference of two signed words
  function automatic logic [DW:0] sub_x(input logic [DW-1:0] a, input logic [DW-1:0] b);
    return {a[DW-1], a} - {b[DW-1], b};
  endfunction

  // magnitude of a difference, always fits DW bits unsigned
  function automatic logic [DW-1:0] mag_x(input logic [DW:0] x);
    logic [DW:0] n;
    n = x[DW] ? (~x + {{DW{1'b0}}, 1'b1}) : x;
    return n[DW-1:0];
  endfunction

  // scale a magnitude product down and saturate with sign
  function automatic satr_t sat_mul(input logic [2*DW-1:0] p, input logic sgn);
    logic [2*DW-1:0] m;
    satr_t           r;
    m = p >> FB;
    if (sgn && (m != '0)) begin
      if (m > {{DW{1'b0}}, MIN_NEG}) begin
        r.v = MIN_NEG;
        r.o = 1'b1;
      end else begin
        r.v = ~m[DW-1:0] + {{(DW-1){1'b0}}, 1'b1};
        r.o = 1'b0;
      end
    end else if (m >= {{DW{1'b0}}, MIN_NEG}) begin
      r.v = MAX_POS;
      r.o = 1'b1;
    end else begin
      r.v = m[DW-1:0];
      r.o = 1'b0;
    end
    return r;
  endfunction

  // saturating signed add
  function automatic satr_t sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    satr_t       r;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      r.v = s[DW] ? MIN_NEG : MAX_POS;
      r.o = 1'b1;
    end else begin
      r.v = s[DW-1:0];
      r.o = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/nci_div_cell.sv
// ----------------------------------------------------------------------------
// nci_div_cell
// One restoring divide step for every lane of a tableau column; the item
// record rides along; both go to the neighbor cell each cycle en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module nci_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  nci_pkg::tab_t   in_tab,
  input  nci_pkg::lanes_t in_lanes,
  output logic            out_valid,
  output nci_pkg::tab_t   out_tab,
  output nci_pkg::lanes_t out_lanes
);
  import nci_pkg::*;

  lanes_t lanes_next;

  // shift one dividend bit into the remainder and try the subtract
  always_comb begin
    logic [DW:0] t;
    logic        ge;
    lanes_next = in_lanes;
    for (int i = 0; i < NL; i++) begin
      t  = {in_lanes[i].r, in_lanes[i].qlo[DW-1]};
      ge = (t >= {1'b0, in_lanes[i].dv});
      if (ge) begin
        t = t - {1'b0, in_lanes[i].dv};
      end
      lanes_next[i].r   = t[DW-1:0];
      lanes_next[i].qlo = {in_lanes[i].qlo[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tab   <= in_tab;
      out_lanes <= lanes_next;
    end
  end

endmodule

`default_nettype wire

### rtl/nci_column.sv
// ----------------------------------------------------------------------------
// nci_column
// One column of the Neville tableau: operand setup, a chain of divide
// cells, quotient saturation, the two products per lane, and the update
// of c, d and the running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module nci_column (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [1:0]    col,
  input  logic          in_valid,
  input  nci_pkg::tab_t in_tab,
  output logic          out_valid,
  output nci_pkg::tab_t out_tab
);
  import nci_pkg::*;

  logic [NL-1:0]      lane_on;
  logic [NL-1:0][1:0] far_idx;

  // lanes live in this column, and the far abscissa of each lane
  always_comb begin
    logic [2:0] j;
    for (int i = 0; i < NL; i++) begin
      lane_on[i] = ((3'(i) + {1'b0, col}) < 3'(NL));
      j          = 3'(i) + {1'b0, col} + 3'd1;
      far_idx[i] = j[1:0];
    end
  end

  // operand setup: numerator and divisor magnitudes
  lanes_t prep_next;
  always_comb begin
    logic [DW:0]   w;
    logic [DW:0]   den;
    logic [DW-1:0] wm;
    logic [DW-1:0] dm;
    prep_next = '0;
    for (int i = 0; i < NL; i++) begin
      w   = sub_x(in_tab.c[i+1], in_tab.d[i]);
      den = sub_x(in_tab.xa[i], in_tab.xa[far_idx[i]]);
      wm  = mag_x(w);
      dm  = mag_x(den);
      prep_next[i].r   = wm >> (DW - FB);
      prep_next[i].qlo = wm << FB;
      prep_next[i].dv  = dm;
      prep_next[i].neg = w[DW] ^ den[DW];
      prep_next[i].big = ((wm >> (DW - FB)) >= dm);
    end
  end

  logic   ch_valid [0:DW];
  tab_t   ch_tab   [0:DW];
  lanes_t ch_lanes [0:DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid[0] <= 1'b0;
    end else if (en) begin
      ch_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_tab[0]   <= in_tab;
      ch_lanes[0] <= prep_next;
    end
  end

  // divide chain, one quotient bit per cell
  for (genvar k = 0; k < DW; k++) begin : g_div
    nci_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (ch_valid[k]),
      .in_tab    (ch_tab[k]),
      .in_lanes  (ch_lanes[k]),
      .out_valid (ch_valid[k+1]),
      .out_tab   (ch_tab[k+1]),
      .out_lanes (ch_lanes[k+1])
    );
  end

  // quotient saturation and product operands
  logic                  s_valid;
  tab_t                  s_tab;
  tab_t                  s_tab_next;
  logic [NL-1:0]         s_qneg, s_qneg_next;
  logic [NL-1:0][DW-1:0] s_qmag, s_qmag_next;
  logic [NL-1:0]         s_honeg, s_honeg_next;
  logic [NL-1:0][DW-1:0] s_homag, s_homag_next;
  logic [NL-1:0]         s_hpneg, s_hpneg_next;
  logic [NL-1:0][DW-1:0] s_hpmag, s_hpmag_next;

  always_comb begin
    logic [DW-1:0] qm;
    logic          o;
    logic [DW:0]   ho;
    logic [DW:0]   hp;
    s_tab_next = ch_tab[DW];
    for (int i = 0; i < NL; i++) begin
      qm = ch_lanes[DW][i].qlo;
      o  = 1'b0;
      if (ch_lanes[DW][i].big) begin
        o              = 1'b1;
        s_qneg_next[i] = ch_lanes[DW][i].neg;
        s_qmag_next[i] = ch_lanes[DW][i].neg ? MIN_NEG : MAX_POS;
      end else if (ch_lanes[DW][i].neg && (qm != '0)) begin
        s_qneg_next[i] = 1'b1;
        if (qm > MIN_NEG) begin
          o              = 1'b1;
          s_qmag_next[i] = MIN_NEG;
        end else begin
          s_qmag_next[i] = qm;
        end
      end else begin
        s_qneg_next[i] = 1'b0;
        if (qm >= MIN_NEG) begin
          o              = 1'b1;
          s_qmag_next[i] = MAX_POS;
        end else begin
          s_qmag_next[i] = qm;
        end
      end
      if (lane_on[i] && o) begin
        s_tab_next.ovf = 1'b1;
      end
      ho = sub_x(ch_tab[DW].xa[i], ch_tab[DW].q);
      hp = sub_x(ch_tab[DW].xa[far_idx[i]], ch_tab[DW].q);
      s_honeg_next[i] = ho[DW];
      s_homag_next[i] = mag_x(ho);
      s_hpneg_next[i] = hp[DW];
      s_hpmag_next[i] = mag_x(hp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (en) begin
      s_valid <= ch_valid[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_tab   <= s_tab_next;
      s_qneg  <= s_qneg_next;
      s_qmag  <= s_qmag_next;
      s_honeg <= s_honeg_next;
      s_homag <= s_homag_next;
      s_hpneg <= s_hpneg_next;
      s_hpmag <= s_hpmag_next;
    end
  end

  // products of the quotient with both distances
  logic                    m_valid;
  tab_t                    m_tab;
  logic [NL-1:0][2*DW-1:0] m_pc;
  logic [NL-1:0][2*DW-1:0] m_pd;
  logic [NL-1:0]           m_sc;
  logic [NL-1:0]           m_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tab <= s_tab;
      for (int i = 0; i < NL; i++) begin
        m_pc[i] <= s_homag[i] * s_qmag[i];
        m_pd[i] <= s_hpmag[i] * s_qmag[i];
        m_sc[i] <= s_honeg[i] ^ s_qneg[i];
        m_sd[i] <= s_hpneg[i] ^ s_qneg[i];
      end
    end
  end

  // tableau update, correction pick and running sum
  tab_t fin_next;
  always_comb begin
    satr_t             rc;
    satr_t             rd;
    satr_t             ys;
    logic [DW-1:0]     dy;
    logic signed [3:0] nsp1;
    logic signed [4:0] lhs;
    logic signed [4:0] rhs;
    fin_next = m_tab;
    for (int i = 0; i < NL; i++) begin
      rd = sat_mul(m_pd[i], m_sd[i]);
      rc = sat_mul(m_pc[i], m_sc[i]);
      if (lane_on[i]) begin
        fin_next.d[i] = rd.v;
        fin_next.c[i] = rc.v;
        if (rd.o || rc.o) begin
          fin_next.ovf = 1'b1;
        end
      end
    end
    nsp1 = 4'(m_tab.ns) + 4'sd1;
    lhs  = {nsp1, 1'b0};
    rhs  = 5'sd3 - $signed({3'b000, col});
    if (lhs < rhs) begin
      dy = fin_next.c[nsp1[1:0]];
    end else begin
      dy          = fin_next.d[m_tab.ns[1:0]];
      fin_next.ns = m_tab.ns - 3'sd1;
    end
    ys         = sat_add(m_tab.y, dy);
    fin_next.y = ys.v;
    if (ys.o) begin
      fin_next.ovf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tab <= fin_next;
    end
  end

endmodule

`default_nettype wire

### rtl/neville_cubic_interpolation.sv
// ----------------------------------------------------------------------------
// neville_cubic_interpolation
// Four-point cubic interpolation by Neville's tableau in signed Q16.16.
//
// Input channel: in_valid/in_stall with four abscissas, four ordinates and
// the query point. Output channel: out_valid/out_stall with the value and
// the equal-abscissa and overflow flags. An item moves when valid is high
// and stall is low.
// The pipeline runs from accept to out_valid through two front stages (check
// and nearest-point search), then three tableau columns of 36 stages each
// (setup, 32 divide cells, saturation, multiply, update), then the output
// buffer. One item is taken every cycle while in_stall is low; the
// 32-cell divide chains are fully pipelined and never hold the flow.
// A two-entry output buffer holds results; while both entries are full the
// whole pipeline holds and in_stall is high, and it resumes as soon as the
// receiver takes a result.
// Reset (rst, synchronous) empties the pipeline and the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module neville_cubic_interpolation (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] abscissa_0,
  input  logic [31:0] abscissa_1,
  input  logic [31:0] abscissa_2,
  input  logic [31:0] abscissa_3,
  input  logic [31:0] ordinate_0,
  input  logic [31:0] ordinate_1,
  input  logic [31:0] ordinate_2,
  input  logic [31:0] ordinate_3,
  input  logic [31:0] query_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] interpolated_value,
  output logic        equal_abscissa_error,
  output logic        overflow_flag
);
  import nci_pkg::*;

  typedef struct packed {
    logic [DW-1:0] v;
    logic          e;
    logic          o;
  } res_t;

  logic       en;
  logic [1:0] cnt;

  assign en       = (cnt != 2'd2);
  assign in_stall = !en;

  // front stage: load item, coincidence check, distances
  logic                    f0_valid;
  tab_t                    f0_tab;
  tab_t                    f0_next;
  logic [NPTS-1:0][DW-1:0] f0_dist;
  logic [NPTS-1:0][DW-1:0] dist_next;

  always_comb begin
    f0_next       = '0;
    f0_next.xa[0] = abscissa_0;
    f0_next.xa[1] = abscissa_1;
    f0_next.xa[2] = abscissa_2;
    f0_next.xa[3] = abscissa_3;
    f0_next.c[0]  = ordinate_0;
    f0_next.c[1]  = ordinate_1;
    f0_next.c[2]  = ordinate_2;
    f0_next.c[3]  = ordinate_3;
    f0_next.d     = f0_next.c;
    f0_next.q     = query_point;
    for (int i = 0; i < NPTS; i++) begin
      dist_next[i] = mag_x(sub_x(query_point, f0_next.xa[i]));
      for (int j = i + 1; j < NPTS; j++) begin
        if (f0_next.xa[i] == f0_next.xa[j]) begin
          f0_next.err = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
    end else if (en) begin
      f0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_tab  <= f0_next;
      f0_dist <= dist_next;
    end
  end

  // nearest abscissa, lower index wins a tie; seeds the running sum
  logic f1_valid;
  tab_t f1_tab;
  tab_t f1_next;

  always_comb begin
    logic [1:0]    best;
    logic [DW-1:0] bd;
    best = 2'd0;
    bd   = f0_dist[0];
    for (int i = 1; i < NPTS; i++) begin
      if (f0_dist[i] < bd) begin
        best = 2'(i);
        bd   = f0_dist[i];
      end
    end
    f1_next    = f0_tab;
    f1_next.y  = f0_tab.c[best];
    f1_next.ns = $signed({1'b0, best}) - 3'sd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= f0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_tab <= f1_next;
    end
  end

  // three tableau columns
  logic col_valid [0:NL];
  tab_t col_tab   [0:NL];

  assign col_valid[0] = f1_valid;
  assign col_tab[0]   = f1_tab;

  for (genvar m = 0; m < NL; m++) begin : g_col
    nci_column u_col (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .col       (2'(m)),
      .in_valid  (col_valid[m]),
      .in_tab    (col_tab[m]),
      .out_valid (col_valid[m+1]),
      .out_tab   (col_tab[m+1])
    );
  end

  // result of the last column, forced to zero on coincident abscissas
  logic push;
  logic pop;
  res_t res_in;

  assign push     = en && col_valid[NL];
  assign pop      = out_valid && !out_stall;
  assign res_in.v = col_tab[NL].err ? '0 : col_tab[NL].y;
  assign res_in.e = col_tab[NL].err;
  assign res_in.o = col_tab[NL].err ? 1'b0 : col_tab[NL].ovf;

  // two-entry output buffer, head drives the ports
  res_t       head, head_next;
  res_t       tail, tail_next;
  logic [1:0] cnt_next;

  always_comb begin
    logic [1:0] left;
    head_next = head;
    tail_next = tail;
    left      = cnt;
    if (pop) begin
      head_next = tail;
      left      = cnt - 2'd1;
    end
    if (push) begin
      if (left == 2'd0) begin
        head_next = res_in;
      end else begin
        tail_next = res_in;
      end
    end
    cnt_next = left + {1'b0, push};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    tail <= tail_next;
  end

  assign out_valid            = (cnt != 2'd0);
  assign interpolated_value   = head.v;
  assign equal_abscissa_error = head.e;
  assign overflow_flag        = head.o;

endmodule

`default_nettype wire
